// File: src/svlcb_pkg.sv
// Shared types, opcodes and helpers for the logic, compare and branch unit.
package svlcb_pkg;

    typedef enum logic [4:0] {
        OP_IAND = 5'd0, OP_IOR = 5'd1, OP_JSR = 5'd2, OP_JSR_W = 5'd3,
        OP_IFNULL = 5'd4, OP_IFNONNULL = 5'd5, OP_GOTO = 5'd6, OP_IFEQ = 5'd7,
        OP_GOTO_W = 5'd8, OP_IXOR = 5'd9, OP_INOT = 5'd10, OP_LAND = 5'd11,
        OP_LOR = 5'd12, OP_LXOR = 5'd13, OP_IF_ICMPEQ = 5'd14, OP_IF_ICMPGT = 5'd15,
        OP_IF_ICMPGE = 5'd16, OP_IF_ICMPLT = 5'd17, OP_IF_ICMPLE = 5'd18,
        OP_IF_ICMPNE = 5'd19, OP_IF_ACMPEQ = 5'd20, OP_IF_ACMPNE = 5'd21,
        OP_IFNE = 5'd22, OP_IFGT = 5'd23, OP_IFGE = 5'd24, OP_IFLT = 5'd25,
        OP_IFLE = 5'd26, OP_LCMP = 5'd27, OP_FCMPL = 5'd28, OP_FCMPG = 5'd29,
        OP_DCMPL = 5'd30, OP_DCMPG = 5'd31
    } t_op;

    localparam logic [31:0] LEN_PLAIN = 32'd1;
    localparam logic [31:0] LEN_SHORT = 32'd3;
    localparam logic [31:0] LEN_WIDE  = 32'd5;
    localparam logic [31:0] CMP_LESS  = 32'hFFFF_FFFF;
    localparam logic [31:0] CMP_EQ    = 32'd0;
    localparam logic [31:0] CMP_MORE  = 32'd1;

    // Stage 1 -> 2: operand decode and partial compares
    typedef struct packed {
        t_op         op;
        logic [63:0] logic_val;
        logic [31:0] target;
        logic [31:0] fallthru;
        logic [31:0] ret_addr;
        logic        a_zero;
        logic        a_neg;
        logic        i_eq;
        logic        i_lt;
        logic        l_eq;
        logic        l_lt;
        logic        f_unord;
        logic        f_zero;
        logic        f_eq;
        logic        f_gt;
        logic        d_unord;
        logic        d_zero;
        logic        d_eq;
        logic        d_gt;
    } t_dec;

    typedef struct packed {
        logic [63:0] push_value;
        logic [1:0]  push_words;
        logic        branch_taken;
        logic [31:0] next_pc;
    } t_res;

    // Order key: monotone unsigned image of an IEEE value
    function automatic logic [63:0] fp_key64(input logic [63:0] v);
        fp_key64 = v[63] ? ~v : (v | 64'h8000_0000_0000_0000);
    endfunction

    function automatic logic [31:0] fp_key32(input logic [31:0] v);
        fp_key32 = v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    function automatic logic [31:0] cmp_word(input logic unord, input logic zero,
                                             input logic eq, input logic gt,
                                             input logic [31:0] nan_res);
        if (unord)           cmp_word = nan_res;
        else if (zero || eq) cmp_word = CMP_EQ;
        else if (gt)         cmp_word = CMP_MORE;
        else                 cmp_word = CMP_LESS;
    endfunction

endpackage

// File: src/stack_vm_logic_compare_branch_unit.sv
// Top level: three-stage pipeline of the logic, compare and branch unit.
//  channel | dir | tdata fields (low to high)                         | tuser
//  s_axis  | in  | command, value_a, value_b, branch_offset, current_pc | -
//  m_axis  | out | push_value, push_words, branch_taken, next_pc      | -
// One item per cycle while the output is not stalled; registers: input reg, decode reg, result reg.
// Each stage holds while the stage after it is full and stalled; nothing drops.
// Reset clears only the stage valid bits.
module stack_vm_logic_compare_branch_unit import svlcb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[4:0], value_a[68:5], value_b[132:69], branch_offset[164:133],
    // current_pc[196:165], zero fill
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // push_value[63:0], push_words[65:64], branch_taken[66], next_pc[98:67], zero fill
    output logic [103:0] m_axis_tdata
);
    logic [196:0] r_in;
    logic         r_v0, r_v1, r_v2;
    t_dec         r_dec, w_dec;
    t_res         r_res, w_res;
    logic         w_en0, w_en1, w_en2;

    assign w_en2 = !r_v2 || m_axis_tready;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en0 = !r_v0 || w_en1;
    assign s_axis_tready = w_en0;

    svlcb_decode u_dec (
        .i_command      (r_in[4:0]),
        .i_value_a      (r_in[68:5]),
        .i_value_b      (r_in[132:69]),
        .i_branch_offset(r_in[164:133]),
        .i_current_pc   (r_in[196:165]),
        .o_dec          (w_dec)
    );

    svlcb_resolve u_res (
        .i_dec(r_dec),
        .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en0) r_v0 <= s_axis_tvalid;
            if (w_en1) r_v1 <= r_v0;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0) r_in  <= s_axis_tdata[196:0];
        if (w_en1) r_dec <= w_dec;
        if (w_en2) r_res <= w_res;
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = {5'd0, r_res.next_pc, r_res.branch_taken,
                            r_res.push_words, r_res.push_value};
endmodule

// File: src/svlcb_decode.sv
// Stage 1: operand logic, address adds and compare flags.
module svlcb_decode import svlcb_pkg::*; (
    input  logic [4:0]  i_command,
    input  logic [63:0] i_value_a,
    input  logic [63:0] i_value_b,
    input  logic [31:0] i_branch_offset,
    input  logic [31:0] i_current_pc,
    output t_dec        o_dec
);
    logic [31:0] w_off;
    logic [31:0] w_len;
    logic [31:0] w_ka32, w_kb32;
    logic [63:0] w_ka64, w_kb64;
    t_op         w_op;

    assign w_op = t_op'(i_command);

    always_comb begin
        w_off = {{16{i_branch_offset[15]}}, i_branch_offset[15:0]};
        w_len = LEN_SHORT;
        if (w_op == OP_JSR_W || w_op == OP_GOTO_W) begin
            w_off = i_branch_offset;
            w_len = LEN_WIDE;
        end else if (i_command == OP_IAND || i_command == OP_IOR || i_command == OP_IXOR
                     || i_command == OP_INOT || i_command == OP_LAND
                     || i_command == OP_LOR || i_command == OP_LXOR
                     || i_command >= OP_LCMP) begin
            w_len = LEN_PLAIN;
        end
    end

    always_comb begin
        case (w_op)
            OP_IAND: o_dec.logic_val = {32'd0, i_value_a[31:0] & i_value_b[31:0]};
            OP_IOR:  o_dec.logic_val = {32'd0, i_value_a[31:0] | i_value_b[31:0]};
            OP_IXOR: o_dec.logic_val = {32'd0, i_value_a[31:0] ^ i_value_b[31:0]};
            OP_INOT: o_dec.logic_val = {32'd0, ~i_value_a[31:0]};
            OP_LAND: o_dec.logic_val = i_value_a & i_value_b;
            OP_LOR:  o_dec.logic_val = i_value_a | i_value_b;
            OP_LXOR: o_dec.logic_val = i_value_a ^ i_value_b;
            default: o_dec.logic_val = 64'd0;
        endcase
    end

    assign w_ka32 = fp_key32(i_value_a[31:0]);
    assign w_kb32 = fp_key32(i_value_b[31:0]);
    assign w_ka64 = fp_key64(i_value_a);
    assign w_kb64 = fp_key64(i_value_b);

    assign o_dec.op       = w_op;
    assign o_dec.target   = i_current_pc + w_off;
    assign o_dec.fallthru = i_current_pc + w_len;
    assign o_dec.ret_addr = i_current_pc + w_len;
    assign o_dec.a_zero   = (i_value_a[31:0] == 32'd0);
    assign o_dec.a_neg    = i_value_a[31];
    assign o_dec.i_eq     = (i_value_a[31:0] == i_value_b[31:0]);
    assign o_dec.i_lt     = ($signed(i_value_a[31:0]) < $signed(i_value_b[31:0]));
    assign o_dec.l_eq     = (i_value_a == i_value_b);
    assign o_dec.l_lt     = ($signed(i_value_a) < $signed(i_value_b));
    assign o_dec.f_unord  = ((&i_value_a[30:23]) && (|i_value_a[22:0]))
                          || ((&i_value_b[30:23]) && (|i_value_b[22:0]));
    assign o_dec.f_zero   = (i_value_a[30:0] == 31'd0) && (i_value_b[30:0] == 31'd0);
    assign o_dec.f_eq     = (w_ka32 == w_kb32);
    assign o_dec.f_gt     = (w_ka32 > w_kb32);
    assign o_dec.d_unord  = ((&i_value_a[62:52]) && (|i_value_a[51:0]))
                          || ((&i_value_b[62:52]) && (|i_value_b[51:0]));
    assign o_dec.d_zero   = (i_value_a[62:0] == 63'd0) && (i_value_b[62:0] == 63'd0);
    assign o_dec.d_eq     = (w_ka64 == w_kb64);
    assign o_dec.d_gt     = (w_ka64 > w_kb64);
endmodule

// File: src/svlcb_resolve.sv
// Stage 2: branch condition, compare word and result select.
module svlcb_resolve import svlcb_pkg::*; (
    input  t_dec i_dec,
    output t_res o_res
);
    logic w_taken;
    logic w_gt;

    assign w_gt = !i_dec.i_lt && !i_dec.i_eq;

    always_comb begin
        w_taken = 1'b0;
        o_res.push_value = i_dec.logic_val;
        o_res.push_words = 2'd1;
        case (i_dec.op)
            OP_JSR, OP_JSR_W: begin
                w_taken = 1'b1;
                o_res.push_value = {32'd0, i_dec.ret_addr};
            end
            OP_GOTO, OP_GOTO_W: w_taken = 1'b1;
            OP_IFNULL, OP_IFEQ:      w_taken = i_dec.a_zero;
            OP_IFNONNULL, OP_IFNE:   w_taken = !i_dec.a_zero;
            OP_IFGT:                 w_taken = !i_dec.a_neg && !i_dec.a_zero;
            OP_IFGE:                 w_taken = !i_dec.a_neg;
            OP_IFLT:                 w_taken = i_dec.a_neg;
            OP_IFLE:                 w_taken = i_dec.a_neg || i_dec.a_zero;
            OP_IF_ICMPEQ, OP_IF_ACMPEQ: w_taken = i_dec.i_eq;
            OP_IF_ICMPNE, OP_IF_ACMPNE: w_taken = !i_dec.i_eq;
            OP_IF_ICMPGT:            w_taken = w_gt;
            OP_IF_ICMPGE:            w_taken = !i_dec.i_lt;
            OP_IF_ICMPLT:            w_taken = i_dec.i_lt;
            OP_IF_ICMPLE:            w_taken = i_dec.i_lt || i_dec.i_eq;
            OP_LAND, OP_LOR, OP_LXOR: o_res.push_words = 2'd2;
            OP_LCMP: o_res.push_value = {32'd0, cmp_word(1'b0, 1'b0, i_dec.l_eq,
                                         !i_dec.l_lt && !i_dec.l_eq, CMP_LESS)};
            OP_FCMPL: o_res.push_value = {32'd0, cmp_word(i_dec.f_unord, i_dec.f_zero,
                                          i_dec.f_eq, i_dec.f_gt, CMP_LESS)};
            OP_FCMPG: o_res.push_value = {32'd0, cmp_word(i_dec.f_unord, i_dec.f_zero,
                                          i_dec.f_eq, i_dec.f_gt, CMP_MORE)};
            OP_DCMPL: o_res.push_value = {32'd0, cmp_word(i_dec.d_unord, i_dec.d_zero,
                                          i_dec.d_eq, i_dec.d_gt, CMP_LESS)};
            OP_DCMPG: o_res.push_value = {32'd0, cmp_word(i_dec.d_unord, i_dec.d_zero,
                                          i_dec.d_eq, i_dec.d_gt, CMP_MORE)};
            default: ;
        endcase
        // all branches push nothing, jsr pushes its return address
        if (i_dec.op != OP_JSR && i_dec.op != OP_JSR_W && (i_dec.op == OP_GOTO
            || i_dec.op == OP_GOTO_W || i_dec.op == OP_IFNULL || i_dec.op == OP_IFNONNULL
            || i_dec.op == OP_IFEQ || (i_dec.op >= OP_IF_ICMPEQ && i_dec.op <= OP_IFLE))) begin
            o_res.push_words = 2'd0;
            o_res.push_value = 64'd0;
        end
        o_res.branch_taken = w_taken;
        o_res.next_pc = w_taken ? i_dec.target : i_dec.fallthru;
    end
endmodule

// File: src/svlcb_checker.sv
// Port-level checker for the logic, compare and branch unit, with its bind.
module svlcb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[65:64] != 2'd3)
        else $error("bad push word count");
    a_branch_nopush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[65:64] == 2'd0 |-> m_axis_tdata[63:0] == 64'd0)
        else $error("branch pushes a value");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind stack_vm_logic_compare_branch_unit svlcb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// File: sim/stack_vm_logic_compare_branch_unit_tb.sv
// Testbench for the logic, compare and branch unit: random and directed bytecodes checked in order.
module stack_vm_logic_compare_branch_unit_tb;
    import svlcb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_op         op;
        logic [63:0] a;
        logic [63:0] b;
        logic [31:0] offset;
        logic [31:0] pc;
    } t_bytecode;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    t_bytecode bytecode_q[$];
    t_res      result_q[$];
    int        errors;
    int        cycle_cnt;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_send;
    bit        feeding_done;

    stack_vm_logic_compare_branch_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic fp_is_nan(input logic [63:0] v, input bit dbl);
        if (dbl)
            return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    // Raw IEEE compare: -1/0/1 as a 32-bit word, unordered gives nan_word.
    function automatic logic [31:0] fp_compare(input logic [63:0] a, input logic [63:0] b,
                                               input bit dbl, input logic [31:0] nan_word);
        logic [63:0] ka;
        logic [63:0] kb;
        if (fp_is_nan(a, dbl) || fp_is_nan(b, dbl))
            return nan_word;
        if (dbl) begin
            if (a[62:0] == 63'd0 && b[62:0] == 63'd0) return CMP_EQ;
            ka = a[63] ? ~a : {1'b1, a[62:0]};
            kb = b[63] ? ~b : {1'b1, b[62:0]};
        end else begin
            if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return CMP_EQ;
            ka = {32'd0, a[31] ? ~a[31:0] : {1'b1, a[30:0]}};
            kb = {32'd0, b[31] ? ~b[31:0] : {1'b1, b[30:0]}};
        end
        if (ka > kb) return CMP_MORE;
        if (ka == kb) return CMP_EQ;
        return CMP_LESS;
    endfunction

    function automatic t_res execute_bytecode(input t_bytecode bc);
        t_res        r;
        logic [31:0] a32;
        logic [31:0] b32;
        logic [31:0] off;
        logic [31:0] len;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        a32 = bc.a[31:0];
        b32 = bc.b[31:0];
        sa = a32;
        sb = b32;
        off = {{16{bc.offset[15]}}, bc.offset[15:0]};
        len = LEN_SHORT;
        r.push_value = '0;
        r.push_words = 2'd0;
        r.branch_taken = 1'b0;
        case (bc.op)
            OP_IAND: begin
                r.push_value = {32'd0, a32 & b32}; r.push_words = 2'd1; len = LEN_PLAIN;
            end
            OP_IOR: begin
                r.push_value = {32'd0, a32 | b32}; r.push_words = 2'd1; len = LEN_PLAIN;
            end
            OP_IXOR: begin
                r.push_value = {32'd0, a32 ^ b32}; r.push_words = 2'd1; len = LEN_PLAIN;
            end
            OP_INOT: begin
                r.push_value = {32'd0, ~a32}; r.push_words = 2'd1; len = LEN_PLAIN;
            end
            OP_LAND: begin
                r.push_value = bc.a & bc.b; r.push_words = 2'd2; len = LEN_PLAIN;
            end
            OP_LOR: begin
                r.push_value = bc.a | bc.b; r.push_words = 2'd2; len = LEN_PLAIN;
            end
            OP_LXOR: begin
                r.push_value = bc.a ^ bc.b; r.push_words = 2'd2; len = LEN_PLAIN;
            end
            OP_JSR: begin
                r.push_value = {32'd0, bc.pc + LEN_SHORT}; r.push_words = 2'd1;
                r.branch_taken = 1'b1;
            end
            OP_JSR_W: begin
                r.push_value = {32'd0, bc.pc + LEN_WIDE}; r.push_words = 2'd1;
                r.branch_taken = 1'b1;
                len = LEN_WIDE; off = bc.offset;
            end
            OP_GOTO:   r.branch_taken = 1'b1;
            OP_GOTO_W: begin r.branch_taken = 1'b1; len = LEN_WIDE; off = bc.offset; end
            OP_IFNULL, OP_IFEQ:   r.branch_taken = (a32 == 32'd0);
            OP_IFNONNULL, OP_IFNE: r.branch_taken = (a32 != 32'd0);
            OP_IFGT: r.branch_taken = (sa > 0);
            OP_IFGE: r.branch_taken = (sa >= 0);
            OP_IFLT: r.branch_taken = (sa < 0);
            OP_IFLE: r.branch_taken = (sa <= 0);
            OP_IF_ICMPEQ, OP_IF_ACMPEQ: r.branch_taken = (a32 == b32);
            OP_IF_ICMPNE, OP_IF_ACMPNE: r.branch_taken = (a32 != b32);
            OP_IF_ICMPGT: r.branch_taken = (sa > sb);
            OP_IF_ICMPGE: r.branch_taken = (sa >= sb);
            OP_IF_ICMPLT: r.branch_taken = (sa < sb);
            OP_IF_ICMPLE: r.branch_taken = (sa <= sb);
            OP_LCMP: begin
                r.push_words = 2'd1; len = LEN_PLAIN;
                if ($signed(bc.a) > $signed(bc.b)) r.push_value = {32'd0, CMP_MORE};
                else if (bc.a == bc.b) r.push_value = {32'd0, CMP_EQ};
                else r.push_value = {32'd0, CMP_LESS};
            end
            OP_FCMPL: begin
                r.push_value = {32'd0, fp_compare(bc.a, bc.b, 1'b0, CMP_LESS)};
                r.push_words = 2'd1; len = LEN_PLAIN;
            end
            OP_FCMPG: begin
                r.push_value = {32'd0, fp_compare(bc.a, bc.b, 1'b0, CMP_MORE)};
                r.push_words = 2'd1; len = LEN_PLAIN;
            end
            OP_DCMPL: begin
                r.push_value = {32'd0, fp_compare(bc.a, bc.b, 1'b1, CMP_LESS)};
                r.push_words = 2'd1; len = LEN_PLAIN;
            end
            default: begin
                r.push_value = {32'd0, fp_compare(bc.a, bc.b, 1'b1, CMP_MORE)};
                r.push_words = 2'd1; len = LEN_PLAIN;
            end
        endcase
        r.next_pc = r.branch_taken ? bc.pc + off : bc.pc + len;
        return r;
    endfunction

    // Pick operands from a pool of interesting bit patterns or fully random.
    function automatic logic [63:0] pick_operand(input t_op op);
        logic [63:0] v;
        int sel;
        sel = $urandom_range(0, 11);
        v = {$urandom, $urandom};
        case (sel)
            0: v = 64'd0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = {$urandom, 32'h8000_0000};
            4: v = {$urandom, 32'h7F80_0000 | ($urandom_range(0, 1) << 31)};
            5: v = {$urandom, 9'h0FF << 22 | 32'($urandom_range(0, 3)) << 22 | $urandom_range(1, 7)};
            6: v = 64'h7FF0_0000_0000_0000 | (64'($urandom_range(0, 1)) << 63)
                   | 64'($urandom_range(0, 3));
            7: v = {$urandom, 32'($urandom_range(0, 3))};
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_bytecode random_bytecode();
        t_bytecode bc;
        bc.op = t_op'($urandom_range(0, 31));
        bc.a = pick_operand(bc.op);
        bc.b = ($urandom_range(0, 4) == 0) ? bc.a : pick_operand(bc.op);
        bc.offset = $urandom;
        bc.pc = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4) : $urandom;
        return bc;
    endfunction

    function automatic logic [199:0] pack_bytecode(input t_bytecode bc);
        return {3'd0, bc.pc, bc.offset, bc.b, bc.a, bc.op};
    endfunction

    task automatic add_bytecode(input t_op op, input logic [63:0] a, input logic [63:0] b,
                                input logic [31:0] offset, input logic [31:0] pc);
        t_bytecode bc;
        bc.op = op; bc.a = a; bc.b = b; bc.offset = offset; bc.pc = pc;
        bytecode_q.push_back(bc);
    endtask

    // Driver: advance to the next bytecode once the current one transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (bytecode_q.size() > 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tdata <= pack_bytecode(bytecode_q[0]);
                result_q.push_back(execute_bytecode(bytecode_q.pop_front()));
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_res got;
        t_res exp_res;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got.push_value   = m_axis_tdata[63:0];
                got.push_words   = m_axis_tdata[65:64];
                got.branch_taken = m_axis_tdata[66];
                got.next_pc      = m_axis_tdata[98:67];
                if (result_q.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    errors++;
                end else begin
                    exp_res = result_q.pop_front();
                    if (got.push_value !== exp_res.push_value) begin
                        $error("push_value exp %h got %h", exp_res.push_value, got.push_value);
                        errors++;
                    end
                    if (got.push_words !== exp_res.push_words) begin
                        $error("push_words exp %0d got %0d", exp_res.push_words, got.push_words);
                        errors++;
                    end
                    if (got.branch_taken !== exp_res.branch_taken) begin
                        $error("branch_taken exp %0d got %0d", exp_res.branch_taken,
                               got.branch_taken);
                        errors++;
                    end
                    if (got.next_pc !== exp_res.next_pc) begin
                        $error("next_pc exp %h got %h", exp_res.next_pc, got.next_pc);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_cnt > 200000) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycle_cnt = 0;
        hold_send = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 87;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every op, NaN and signed-zero compares, wide offsets, pc wrap.
        for (int op = 0; op < 32; op++)
            add_bytecode(t_op'(op), 64'hFFFF_FFFF_0000_8001, 64'h0000_0000_FFFF_FFFF,
                         32'h8000_7FFC, 32'hFFFF_FFFE);
        add_bytecode(OP_FCMPL, 64'h7FC0_0000, 64'd0, 32'd0, 32'd0);
        add_bytecode(OP_FCMPG, 64'h7FC0_0000, 64'd0, 32'd0, 32'd0);
        add_bytecode(OP_DCMPL, 64'd0, 64'hFFF8_0000_0000_0001, 32'd0, 32'd0);
        add_bytecode(OP_DCMPG, 64'd0, 64'hFFF8_0000_0000_0001, 32'd0, 32'd0);
        add_bytecode(OP_FCMPG, 64'h8000_0000, 64'd0, 32'd0, 32'd0);
        add_bytecode(OP_DCMPL, 64'h8000_0000_0000_0000, 64'd0, 32'd0, 32'd0);
        add_bytecode(OP_GOTO_W, 64'd0, 64'd0, 32'h7FFF_FFFF, 32'h1000);
        add_bytecode(OP_JSR_W, 64'd0, 64'd0, 32'h8000_0000, 32'hFFFF_FFFD);
        for (int i = 0; i < 300; i++) bytecode_q.push_back(random_bytecode());
        wait (bytecode_q.size() == 0);

        // Hold the sender until every result is in, then swap idle rates.
        hold_send = 1'b1;
        wait (result_q.size() == 0);
        @(posedge i_clk);
        hold_send = 1'b0;
        send_idle_pct = 87;
        recv_idle_pct = 17;
        for (int i = 0; i < 300; i++) bytecode_q.push_back(random_bytecode());
        wait (bytecode_q.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 300; i++) bytecode_q.push_back(random_bytecode());
        wait (bytecode_q.size() == 0);
        wait (result_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
